@@ design/assert_macros.svh @@
// assertion macros used by the top level rtl file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define OLE_ASSERT_IMPL(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error("assertion failed");
`define OLE_ASSERT_NEXT(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("assertion failed");
`else
`define OLE_ASSERT_IMPL(label, clk, rst_n, cond, conseq)
`define OLE_ASSERT_NEXT(label, clk, rst_n, cond, conseq)
`endif
`endif

@@ design/ole_pkg.sv @@
// shared types and codes of the ordered list engine
// no dependencies
package ole_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int ITEM_WIDTH_DEF = 32;
    localparam int POS_W          = 7;
    localparam int VAL_W          = 32;
    localparam int IN_W           = 48;
    localparam int OUT_W          = 56;

    typedef enum logic [2:0] {
        OP_INS_AT   = 3'd0,
        OP_INS_SORT = 3'd1,
        OP_ERASE    = 3'd2,
        OP_RMALL    = 3'd3,
        OP_GET      = 3'd4,
        OP_SET      = 3'd5,
        OP_FIND     = 3'd6,
        OP_NOP      = 3'd7
    } op_t;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_RANGE    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        op_t              op;
        logic [POS_W-1:0] pos;
    } cmd_t;

endpackage

@@ design/ole_ram.sv @@
// generic single write, single read ram with registered read
// no dependencies
module ole_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

@@ design/ole_front.sv @@
// front: takes input words, decodes the mode and queues commands
// depends on ole_pkg
module ole_front #(
    parameter int ITEM_WIDTH = ole_pkg::ITEM_WIDTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [ole_pkg::IN_W-1:0] s_tdata,
    output logic                    q_valid,
    input  logic                    q_ready,
    output ole_pkg::cmd_t           q_cmd,
    output logic [ITEM_WIDTH-1:0]   q_val
);
    import ole_pkg::*;

    cmd_t                  cmd_reg [2];
    logic [ITEM_WIDTH-1:0] val_reg [2];
    logic                  wr_ptr_reg, rd_ptr_reg;
    logic [1:0]            cnt_reg;
    logic [63:0]           val_wide;
    cmd_t                  in_cmd;
    logic                  push, pop;

    // decode the incoming word
    always_comb
    begin
        in_cmd.op  = op_t'(s_tdata[2:0]);
        in_cmd.pos = s_tdata[9:3];
        val_wide   = {32'b0, s_tdata[41:10]};
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;
    assign q_cmd    = cmd_reg[rd_ptr_reg];
    assign q_val    = val_reg[rd_ptr_reg];

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            cmd_reg[wr_ptr_reg] <= in_cmd;
            val_reg[wr_ptr_reg] <= val_wide[ITEM_WIDTH-1:0];
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end
endmodule

@@ design/ole_back.sv @@
// back: carries out list commands over the item ram, one entry per cycle
// depends on ole_pkg and ole_ram
module ole_back #(
    parameter int CAPACITY   = ole_pkg::CAPACITY_DEF,
    parameter int ITEM_WIDTH = ole_pkg::ITEM_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_valid,
    output logic                      q_ready,
    input  ole_pkg::cmd_t             q_cmd,
    input  logic [ITEM_WIDTH-1:0]     q_val,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [ole_pkg::OUT_W-1:0] m_tdata
);
    import ole_pkg::*;

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PUT  = 4'd1;
    localparam logic [3:0] S_SHUP = 4'd2;
    localparam logic [3:0] S_SRCH = 4'd3;
    localparam logic [3:0] S_SHDN = 4'd4;
    localparam logic [3:0] S_RMV  = 4'd5;
    localparam logic [3:0] S_FIND = 4'd6;
    localparam logic [3:0] S_GETW = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    logic [3:0]            state_reg, state_next;
    logic [CNT_W-1:0]      total_reg, total_next;
    logic [CMP_W-1:0]      pos_reg, pos_next;
    logic [ITEM_WIDTH-1:0] val_reg, val_next;
    logic [ADDR_W-1:0]     ra_reg, ra_next, last_reg, last_next, da_reg, da_next;
    logic [ADDR_W-1:0]     w_reg, w_next;
    logic                  issue_reg, issue_next, dv_reg, dv_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [1:0]            st_reg, st_next;
    logic [CMP_W-1:0]      idx_reg, idx_next;
    logic [ITEM_WIDTH-1:0] rval_reg, rval_next;
    logic                  out_valid_reg;
    logic [OUT_W-1:0]      out_data_reg;

    logic                  we, re;
    logic [ADDR_W-1:0]     waddr, raddr;
    logic [ITEM_WIDTH-1:0] wdata, rdata;
    logic [CMP_W-1:0]      tot_x, qpos_x, cnt_x;
    logic [ADDR_W-1:0]     tot_m1, pos_a, qpos_a;
    logic                  full, eq, load_out;
    logic [CNT_W-1:0]      cnt_inc;
    logic [63:0]           rval_wide;

    ole_ram #(.WIDTH(ITEM_WIDTH), .DEPTH(CAPACITY)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign tot_x    = CMP_W'(total_reg);
    assign tot_m1   = ADDR_W'(total_reg - CNT_W'(1));
    assign qpos_x   = CMP_W'(q_cmd.pos);
    assign qpos_a   = qpos_x[ADDR_W-1:0];
    assign pos_a    = pos_reg[ADDR_W-1:0];
    assign cnt_x    = CMP_W'(cnt_reg);
    assign full     = (total_reg == CNT_W'(CAPACITY));
    assign eq       = (rdata == val_reg);
    assign cnt_inc  = cnt_reg + CNT_W'(1);
    assign q_ready  = (state_reg == S_IDLE);
    assign load_out = (state_reg == S_OUT) && (!out_valid_reg || m_tready);
    assign rval_wide = 64'(rval_reg);

    // command sequencer
    always_comb
    begin
        state_next = state_reg;
        total_next = total_reg;
        pos_next   = pos_reg;
        val_next   = val_reg;
        ra_next    = ra_reg;
        last_next  = last_reg;
        da_next    = da_reg;
        w_next     = w_reg;
        issue_next = issue_reg;
        dv_next    = 1'b0;
        cnt_next   = cnt_reg;
        st_next    = st_reg;
        idx_next   = idx_reg;
        rval_next  = rval_reg;
        we         = 1'b0;
        waddr      = '0;
        wdata      = val_reg;
        re         = 1'b0;
        raddr      = ra_reg;

        // shared walk: one read a cycle, data arrives the next cycle
        if (state_reg == S_SHUP || state_reg == S_SRCH || state_reg == S_SHDN ||
            state_reg == S_RMV || state_reg == S_FIND)
        begin
            re      = issue_reg;
            dv_next = issue_reg;
            da_next = ra_reg;
            if (issue_reg)
            begin
                if (ra_reg == last_reg)
                begin
                    issue_next = 1'b0;
                end
                else if (state_reg == S_SHUP)
                begin
                    ra_next = ra_reg - ADDR_W'(1);
                end
                else
                begin
                    ra_next = ra_reg + ADDR_W'(1);
                end
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    pos_next   = qpos_x;
                    val_next   = q_val;
                    st_next    = ST_OK;
                    idx_next   = '0;
                    rval_next  = '0;
                    cnt_next   = '0;
                    w_next     = '0;
                    issue_next = 1'b1;
                    ra_next    = '0;
                    last_next  = tot_m1;
                    state_next = S_OUT;
                    unique case (q_cmd.op)
                        OP_INS_AT:
                        begin
                            if (qpos_x > tot_x)
                            begin
                                st_next = ST_RANGE;
                            end
                            else if (full)
                            begin
                                st_next = ST_FULL;
                            end
                            else if (qpos_x == tot_x)
                            begin
                                state_next = S_PUT;
                            end
                            else
                            begin
                                ra_next    = tot_m1;
                                last_next  = qpos_a;
                                state_next = S_SHUP;
                            end
                        end
                        OP_INS_SORT:
                        begin
                            if (full)
                            begin
                                st_next = ST_FULL;
                            end
                            else if (total_reg == '0)
                            begin
                                pos_next   = '0;
                                state_next = S_PUT;
                            end
                            else
                            begin
                                state_next = S_SRCH;
                            end
                        end
                        OP_ERASE:
                        begin
                            if (qpos_x >= tot_x)
                            begin
                                st_next = ST_RANGE;
                            end
                            else if (qpos_a == tot_m1)
                            begin
                                total_next = total_reg - CNT_W'(1);
                                idx_next   = qpos_x;
                            end
                            else
                            begin
                                ra_next    = qpos_a + ADDR_W'(1);
                                state_next = S_SHDN;
                            end
                        end
                        OP_RMALL:
                        begin
                            if (total_reg != '0)
                            begin
                                state_next = S_RMV;
                            end
                        end
                        OP_GET:
                        begin
                            if (qpos_x >= tot_x)
                            begin
                                st_next = ST_RANGE;
                            end
                            else
                            begin
                                re         = 1'b1;
                                raddr      = qpos_a;
                                state_next = S_GETW;
                            end
                        end
                        OP_SET:
                        begin
                            if (qpos_x >= tot_x)
                            begin
                                st_next = ST_RANGE;
                            end
                            else
                            begin
                                we       = 1'b1;
                                waddr    = qpos_a;
                                wdata    = q_val;
                                idx_next = qpos_x;
                            end
                        end
                        OP_FIND:
                        begin
                            if (total_reg == '0)
                            begin
                                st_next = ST_NOTFOUND;
                            end
                            else
                            begin
                                state_next = S_FIND;
                            end
                        end
                        default:
                        begin
                            st_next = ST_OK;
                        end
                    endcase
                end
            end
            // place the new item into the opened gap
            S_PUT:
            begin
                we         = 1'b1;
                waddr      = pos_a;
                total_next = total_reg + CNT_W'(1);
                idx_next   = pos_reg;
                state_next = S_OUT;
            end
            // move items up by one, from the top down
            S_SHUP:
            begin
                if (dv_reg)
                begin
                    we    = 1'b1;
                    waddr = da_reg + ADDR_W'(1);
                    wdata = rdata;
                    if (da_reg == last_reg)
                    begin
                        state_next = S_PUT;
                    end
                end
            end
            // find the first item not below the value
            S_SRCH:
            begin
                if (dv_reg)
                begin
                    if (val_reg <= rdata)
                    begin
                        pos_next   = CMP_W'(da_reg);
                        ra_next    = tot_m1;
                        last_next  = da_reg;
                        issue_next = 1'b1;
                        dv_next    = 1'b0;
                        state_next = S_SHUP;
                    end
                    else if (da_reg == last_reg)
                    begin
                        pos_next   = tot_x;
                        state_next = S_PUT;
                    end
                end
            end
            // move items down by one over the erased entry
            S_SHDN:
            begin
                if (dv_reg)
                begin
                    we    = 1'b1;
                    waddr = da_reg - ADDR_W'(1);
                    wdata = rdata;
                    if (da_reg == last_reg)
                    begin
                        total_next = total_reg - CNT_W'(1);
                        idx_next   = pos_reg;
                        state_next = S_OUT;
                    end
                end
            end
            // compact the list, dropping matches
            S_RMV:
            begin
                if (dv_reg)
                begin
                    if (eq)
                    begin
                        cnt_next = cnt_inc;
                    end
                    else
                    begin
                        we     = 1'b1;
                        waddr  = w_reg;
                        wdata  = rdata;
                        w_next = w_reg + ADDR_W'(1);
                    end
                    if (da_reg == last_reg)
                    begin
                        total_next = total_reg - (eq ? cnt_inc : cnt_reg);
                        cnt_next   = eq ? cnt_inc : cnt_reg;
                        state_next = S_OUT;
                    end
                end
            end
            S_FIND:
            begin
                if (dv_reg)
                begin
                    if (eq)
                    begin
                        idx_next   = CMP_W'(da_reg);
                        state_next = S_OUT;
                    end
                    else if (da_reg == last_reg)
                    begin
                        st_next    = ST_NOTFOUND;
                        state_next = S_OUT;
                    end
                end
            end
            S_GETW:
            begin
                rval_next  = rdata;
                idx_next   = pos_reg;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= '0;
            issue_reg     <= 1'b0;
            dv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            issue_reg <= issue_next;
            dv_reg    <= dv_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        val_reg  <= val_next;
        ra_reg   <= ra_next;
        last_reg <= last_next;
        da_reg   <= da_next;
        w_reg    <= w_next;
        cnt_reg  <= cnt_next;
        st_reg   <= st_next;
        idx_reg  <= idx_next;
        rval_reg <= rval_next;
        if (load_out)
        begin
            out_data_reg <= {1'b0, tot_x[POS_W-1:0], cnt_x[POS_W-1:0],
                             rval_wide[VAL_W-1:0], idx_reg[POS_W-1:0], st_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
endmodule

@@ design/ordered_list_engine_unit.sv @@
// top level of the ordered list engine
// depends on ole_pkg, ole_front, ole_back, assert_macros.svh
//
// channel  dir  word bits  fields (lowest bit up)
// s_axis   in   48         mode, position, item_value
// m_axis   out  56         status, result_index, read_value, removed_count, item_count
//
// set and get touch a single entry; inserts, erase, remove all and find walk the
// item ram one entry per cycle when there are entries to move or scan
// reset (rst_n, async) empties the list and the command queue; ram content is not cleared
// a two entry queue keeps taking words, until both entries are full, while the back end works or the result stalls
`include "assert_macros.svh"
module ordered_list_engine_unit #(
    parameter int CAPACITY   = ole_pkg::CAPACITY_DEF,
    parameter int ITEM_WIDTH = ole_pkg::ITEM_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [ole_pkg::IN_W-1:0]  s_tdata,  // mode, position, item_value
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [ole_pkg::OUT_W-1:0] m_tdata   // status, result_index, read_value,
                                                // removed_count, item_count
);
    import ole_pkg::*;

    logic                  q_valid, q_ready;
    cmd_t                  q_cmd;
    logic [ITEM_WIDTH-1:0] q_val;
    logic                  res_failed, res_clean;

    ole_front #(.ITEM_WIDTH(ITEM_WIDTH)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd),
        .q_val    (q_val)
    );

    ole_back #(.CAPACITY(CAPACITY), .ITEM_WIDTH(ITEM_WIDTH)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd),
        .q_val    (q_val),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // result word classification for the checks below
    assign res_failed = m_tvalid && (m_tdata[1:0] != ST_OK);
    assign res_clean  = (m_tdata[47:41] == '0) && (m_tdata[40:9] == '0);

    // failures never report removed items or read data
    `OLE_ASSERT_IMPL(a_fail_clean, clk, rst_n, res_failed, res_clean)
    // a word in the output register holds until taken
    `OLE_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // an empty queue always takes a word
    `OLE_ASSERT_IMPL(a_queue_ready, clk, rst_n, !q_valid, s_tready)
endmodule

@@ tb/sv/tb.sv @@
// testbench of the ordered list engine: random and directed requests with a local list predictor
// depends on ole_pkg and ordered_list_engine_unit
module tb;
    import ole_pkg::*;

    localparam int CAP = 64;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    typedef struct packed {
        logic [6:0]  item_count;
        logic [6:0]  removed_count;
        logic [31:0] read_value;
        logic [6:0]  result_index;
        logic [1:0]  status;
    } reply_t;

    // predictor state
    logic [31:0] list_items [CAP];
    int list_len = 0;
    reply_t reply_q[$];
    int fail_count = 0;

    ordered_list_engine_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #2 clk = ~clk;

    // compute the reply of one request and update the list
    function automatic reply_t list_apply(op_t op, logic [6:0] pos, logic [31:0] val);
        reply_t r;
        int k;
        int w;
        r = '0;
        case (op)
            OP_INS_AT:
            begin
                if (pos > list_len) r.status = ST_RANGE;
                else if (list_len >= CAP) r.status = ST_FULL;
                else
                begin
                    for (k = list_len; k > pos; k--) list_items[k] = list_items[k-1];
                    list_items[pos] = val;
                    list_len++;
                    r.result_index = pos;
                end
            end
            OP_INS_SORT:
            begin
                if (list_len >= CAP) r.status = ST_FULL;
                else
                begin
                    for (w = 0; w < list_len; w++) if (val <= list_items[w]) break;
                    for (k = list_len; k > w; k--) list_items[k] = list_items[k-1];
                    list_items[w] = val;
                    list_len++;
                    r.result_index = w[6:0];
                end
            end
            OP_ERASE:
            begin
                if (pos >= list_len) r.status = ST_RANGE;
                else
                begin
                    for (k = pos; k + 1 < list_len; k++) list_items[k] = list_items[k+1];
                    list_len--;
                    r.result_index = pos;
                end
            end
            OP_RMALL:
            begin
                w = 0;
                for (k = 0; k < list_len; k++)
                    if (list_items[k] == val) r.removed_count++;
                    else list_items[w++] = list_items[k];
                list_len = w;
            end
            OP_GET:
            begin
                if (pos >= list_len) r.status = ST_RANGE;
                else
                begin
                    r.read_value = list_items[pos];
                    r.result_index = pos;
                end
            end
            OP_SET:
            begin
                if (pos >= list_len) r.status = ST_RANGE;
                else
                begin
                    list_items[pos] = val;
                    r.result_index = pos;
                end
            end
            OP_FIND:
            begin
                r.status = ST_NOTFOUND;
                for (k = 0; k < list_len; k++)
                    if (list_items[k] == val)
                    begin
                        r.status = ST_OK;
                        r.result_index = k[6:0];
                        break;
                    end
            end
            default: ;
        endcase
        r.item_count = list_len[6:0];
        return r;
    endfunction

    // send one word after a random gap; valid stays high when the gap is zero
    task automatic send_req(op_t op, logic [6:0] pos, logic [31:0] val);
        int gap;
        gap = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, val, pos, op};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        reply_q.push_back(list_apply(op, pos, val));
    endtask

    // receiver with random stalls
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    // check each accepted result word
    always @(posedge clk)
    begin
        reply_t got;
        reply_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[$bits(reply_t)-1:0];
            if (reply_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10) $display("unexpected result word %h", m_tdata);
            end
            else
            begin
                want = reply_q.pop_front();
                if (got !== want)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: expected st=%0d idx=%0d val=%h rm=%0d cnt=%0d,",
                            want.status, want.result_index, want.read_value,
                            want.removed_count, want.item_count,
                            " got st=%0d idx=%0d val=%h rm=%0d cnt=%0d",
                            got.status, got.result_index, got.read_value,
                            got.removed_count, got.item_count);
                end
            end
        end
    end

    function automatic logic [31:0] rand_val();
        case ($urandom_range(0, 4))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 7);
            default: return $urandom;
        endcase
    endfunction

    // edge cases on an empty and a small list
    task automatic test_directed();
        send_req(OP_GET, 7'd0, 32'd0);
        send_req(OP_ERASE, 7'd0, 32'd0);
        send_req(OP_SET, 7'd0, 32'd5);
        send_req(OP_FIND, 7'd0, 32'd1);
        send_req(OP_RMALL, 7'd0, 32'd1);
        send_req(OP_INS_AT, 7'd1, 32'd9);
        send_req(OP_INS_AT, 7'd0, 32'hFFFF_FFFF);
        send_req(OP_INS_SORT, 7'd0, 32'd0);
        send_req(OP_INS_AT, 7'd2, 32'd7);
        send_req(OP_GET, 7'd2, 32'd0);
        send_req(OP_SET, 7'd1, 32'd7);
        send_req(OP_FIND, 7'd0, 32'd7);
        send_req(OP_RMALL, 7'd0, 32'd7);
        send_req(OP_NOP, 7'h7F, 32'hFFFF_FFFF);
        send_req(OP_GET, 7'h7F, 32'd0);
        send_req(OP_INS_AT, 7'h7F, 32'd0);
    endtask

    // fill to capacity then hit the full cases
    task automatic test_full();
        while (list_len < CAP) send_req(OP_INS_SORT, 7'd0, rand_val());
        send_req(OP_INS_AT, 7'd64, 32'd1);
        send_req(OP_INS_AT, 7'd65, 32'd1);
        send_req(OP_INS_SORT, 7'd0, 32'd1);
        send_req(OP_GET, 7'd63, 32'd0);
        send_req(OP_GET, 7'd64, 32'd0);
        send_req(OP_ERASE, 7'd63, 32'd0);
        send_req(OP_INS_AT, 7'd63, 32'hA5A5_5A5A);
        send_req(OP_RMALL, 7'd0, 32'hFFFF_FFFF);
    endtask

    // random mix, positions mostly in range
    task automatic test_random(int n);
        int i;
        logic [6:0] pos;
        for (i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) == 0) pos = 7'($urandom);
            else pos = 7'($urandom_range(0, list_len));
            if (list_len < 8 && $urandom_range(0, 1) == 0)
                send_req(op_t'($urandom_range(0, 1)), pos, rand_val());
            else
                send_req(op_t'($urandom_range(0, 7)), pos, rand_val());
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full();
        test_random(1300);
        s_tvalid <= 1'b0;
        while (reply_q.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("Test completed with failures");
        $finish;
    end
endmodule
